### sv/penalty_contact_force_stribeck_macros.svh
// Assertion macros used by the checker of the contact force block.
`ifndef PENALTY_CONTACT_FORCE_STRIBECK_MACROS_SVH
`define PENALTY_CONTACT_FORCE_STRIBECK_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define PCFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PCFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pcfs_pkg.sv
`default_nettype none

package pcfs_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_STIFFNESS = 2'd0;
    localparam logic [1:0] REG_DAMPING   = 2'd1;
    localparam logic [1:0] REG_INV_TOL   = 2'd2;

    // Reset value of the inverse stiction tolerance (1.0 in Q16.16).
    localparam logic [30:0] INV_TOL_RESET = 31'd65536;

    // Pipeline depths of the iterative units.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    typedef struct packed {
        logic        [30:0] depth;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] rel_vel_x;
        logic signed [31:0] rel_vel_y;
        logic signed [31:0] rel_vel_z;
        logic        [30:0] stiction_coef;
        logic        [30:0] sliding_coef;
    } pcfs_in_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               in_contact;
    } pcfs_out_t;

    // Per-request values that travel down the back half of the pipeline.
    typedef struct packed {
        logic             contact;
        logic [2:0][31:0] fnv;
        logic [2:0][31:0] vt;
        logic [31:0]      fn;
        logic [30:0]      mu_s;
        logic [30:0]      mu_d;
    } pcfs_carry_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        if (v > 67'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -67'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/pcfs_front.sv
`default_nettype none

// Normal force and squared tangential speed, ten register stages.
module pcfs_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire pcfs_pkg::pcfs_in_t     in_data,
    input  wire logic [30:0]            k,
    input  wire logic [30:0]            d,
    output logic                        out_valid,
    output logic [63:0]                 sq,
    output pcfs_pkg::pcfs_carry_t       carry
);

    logic [9:0] vld_reg;

    logic signed [31:0] n_in [3];
    logic signed [31:0] v_in [3];

    pcfs_pkg::pcfs_in_t in1_reg, in2_reg, in3_reg, in4_reg, in5_reg, in6_reg, in7_reg;
    logic signed [63:0] p1_reg [3];
    logic        [61:0] kxp1_reg;
    logic signed [31:0] vn2_reg, vn3_reg, vn4_reg, vn5_reg, vn6_reg;
    logic        [30:0] kx2_reg, kx3_reg, kx4_reg;
    logic signed [63:0] dvp3_reg;
    logic signed [31:0] damp4_reg;
    logic signed [63:0] fkp5_reg;
    logic signed [31:0] fn6_reg, fn7_reg;
    logic signed [63:0] fnp7_reg [3];
    logic signed [63:0] vnp7_reg [3];
    pcfs_pkg::pcfs_carry_t carry8_reg, carry9_reg, carry10_reg;
    logic        [63:0] sq9_reg [3];
    logic        [63:0] sq10_reg;

    logic signed [66:0] sum2;
    logic signed [31:0] v7 [3];
    logic signed [31:0] n7 [3];
    logic        [31:0] abs8 [3];

    assign n_in[0] = in_data.normal_x;
    assign n_in[1] = in_data.normal_y;
    assign n_in[2] = in_data.normal_z;
    assign v_in[0] = in_data.rel_vel_x;
    assign v_in[1] = in_data.rel_vel_y;
    assign v_in[2] = in_data.rel_vel_z;

    assign v7[0] = in7_reg.rel_vel_x;
    assign v7[1] = in7_reg.rel_vel_y;
    assign v7[2] = in7_reg.rel_vel_z;
    assign n7[0] = in6_reg.normal_x;
    assign n7[1] = in6_reg.normal_y;
    assign n7[2] = in6_reg.normal_z;

    // Exact sum of the three velocity-normal products.
    assign sum2 = 67'(p1_reg[0]) + 67'(p1_reg[1]) + 67'(p1_reg[2]);

    // Absolute tangential components ahead of squaring.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs8[i] = carry8_reg.vt[i][31] ? 32'(-carry8_reg.vt[i]) : carry8_reg.vt[i];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[8:0], in_valid};
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1: products for the normal speed and k*x.
            in1_reg <= in_data;
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= v_in[i] * n_in[i];
            end
            kxp1_reg <= in_data.depth * k;

            // Stage 2: normal speed and stiffness term.
            in2_reg <= in1_reg;
            vn2_reg <= pcfs_pkg::sat32(sum2 >>> 16);
            kx2_reg <= (|kxp1_reg[61:47]) ? 31'h7FFFFFFF : kxp1_reg[46:16];

            // Stage 3: damping product.
            in3_reg  <= in2_reg;
            vn3_reg  <= vn2_reg;
            kx3_reg  <= kx2_reg;
            dvp3_reg <= $signed({1'b0, d}) * vn2_reg;

            // Stage 4: damping factor 1 + d*vn.
            in4_reg   <= in3_reg;
            vn4_reg   <= vn3_reg;
            kx4_reg   <= kx3_reg;
            damp4_reg <= pcfs_pkg::sat32(67'(dvp3_reg >>> 16) + 67'sd65536);

            // Stage 5: normal force product.
            in5_reg  <= in4_reg;
            vn5_reg  <= vn4_reg;
            fkp5_reg <= $signed({1'b0, kx4_reg}) * damp4_reg;

            // Stage 6: normal force magnitude.
            in6_reg <= in5_reg;
            vn6_reg <= vn5_reg;
            fn6_reg <= pcfs_pkg::sat32(67'(fkp5_reg >>> 16));

            // Stage 7: force and normal velocity projected on each axis.
            in7_reg <= in6_reg;
            fn7_reg <= fn6_reg;
            for (int i = 0; i < 3; i++)
            begin
                fnp7_reg[i] <= fn6_reg * n7[i];
                vnp7_reg[i] <= vn6_reg * n7[i];
            end

            // Stage 8: normal force vector and tangential velocity.
            carry8_reg.contact <= (fn7_reg > 32'sd0);
            carry8_reg.fn      <= fn7_reg;
            carry8_reg.mu_s    <= in7_reg.stiction_coef;
            carry8_reg.mu_d    <= in7_reg.sliding_coef;
            for (int i = 0; i < 3; i++)
            begin
                carry8_reg.fnv[i] <= pcfs_pkg::sat32(67'(fnp7_reg[i] >>> 16));
                carry8_reg.vt[i]  <= pcfs_pkg::sat32(67'(v7[i])
                    - 67'(pcfs_pkg::sat32(67'(vnp7_reg[i] >>> 16))));
            end

            // Stage 9: squares of the tangential components.
            carry9_reg <= carry8_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq9_reg[i] <= abs8[i] * abs8[i];
            end

            // Stage 10: squared tangential speed.
            carry10_reg <= carry9_reg;
            sq10_reg    <= sq9_reg[0] + sq9_reg[1] + sq9_reg[2];
        end
    end

    assign out_valid = vld_reg[9];
    assign sq        = sq10_reg;
    assign carry     = carry10_reg;

endmodule

`default_nettype wire

### sv/pcfs_sqrt.sv
`default_nettype none

// Pipelined digit-by-digit square root, one result bit per stage.
module pcfs_sqrt (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [63:0]            sq,
    input  wire pcfs_pkg::pcfs_carry_t  carry_in,
    output logic                        out_valid,
    output logic [31:0]                 root,
    output logic                        nz,
    output pcfs_pkg::pcfs_carry_t       carry_out
);

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
        pcfs_pkg::pcfs_carry_t carry;
    } sqrt_st_t;

    localparam int N = pcfs_pkg::SQRT_STEPS;

    logic [N-1:0] vld_reg;
    sqrt_st_t     st_reg [1:N];
    sqrt_st_t     first;

    assign first = '{rad: sq, rem: '0, root: '0, carry: carry_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_step
        sqrt_st_t    src;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic        ge;

        if (g == 0)
        begin : g_first
            assign src = first;
        end
        else
        begin : g_next
            assign src = st_reg[g];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign rem_sh = {src.rem, src.rad[63-2*g -: 2]};
        assign trial  = {2'b00, src.root, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g+1].rad   <= src.rad;
                st_reg[g+1].carry <= src.carry;
                st_reg[g+1].rem   <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
                st_reg[g+1].root  <= {src.root[30:0], ge};
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = st_reg[N].root;
    assign nz        = |st_reg[N].rad;
    assign carry_out = st_reg[N].carry;

endmodule

`default_nettype wire

### sv/pcfs_fric.sv
`default_nettype none

// Stribeck coefficient, friction magnitude and the dividends ft*vt_i.
module pcfs_fric (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [31:0]            speed,
    input  wire logic                   nz,
    input  wire pcfs_pkg::pcfs_carry_t  carry_in,
    input  wire logic [30:0]            inv_tol,
    output logic                        out_valid,
    output logic [2:0][63:0]            np,
    output logic [31:0]                 speed_out,
    output logic                        nz_out,
    output pcfs_pkg::pcfs_carry_t       carry_out
);

    localparam int N = 10;

    logic [N-1:0]          vld_reg;
    pcfs_pkg::pcfs_carry_t carry_reg [N];
    logic [31:0]           speed_reg [N];
    logic                  nz_reg    [N];
    logic                  mid_reg   [1:5];
    logic                  big_reg   [1:5];

    logic        [62:0] sp1_reg;
    logic        [15:0] u2_reg, u3_reg;
    logic        [31:0] uu3_reg;
    logic signed [38:0] pl3_reg;
    logic        [31:0] u3p4_reg;
    logic        [19:0] poly4_reg;
    logic        [35:0] stp5_reg;
    logic signed [53:0] mprod6_reg;
    logic signed [31:0] mu7_reg;
    logic signed [63:0] ftp8_reg;
    logic signed [31:0] ft9_reg;
    logic        [2:0][63:0] np10_reg;

    logic        [46:0] s1;
    logic        [17:0] sm1;
    logic signed [21:0] lin2;
    logic signed [38:0] polyw3;
    logic        [19:0] step5;
    logic signed [32:0] diff5;
    logic signed [32:0] mult5;
    logic signed [53:0] sh6;
    logic signed [66:0] mu6;

    // Scaled speed and the smoothstep argument.
    assign s1  = sp1_reg[62:16];
    assign sm1 = s1[17:0] - 18'd65536;

    // Linear factor 6u - 15 of the quintic.
    assign lin2 = $signed({6'b0, u2_reg}) * 22'sd6 - 22'sd983040;

    // Polynomial 10 + u*(6u - 15), always positive on [0, 1).
    assign polyw3 = (pl3_reg >>> 16) + 39'sd655360;

    // Smoothstep value and the coefficient blend operand.
    assign step5 = stp5_reg[35:16];
    assign diff5 = $signed({2'b00, carry_reg[4].mu_s}) - $signed({2'b00, carry_reg[4].mu_d});
    assign mult5 = mid_reg[4] ? diff5 : $signed({2'b00, carry_reg[4].mu_s});

    // Blended coefficient for the three speed ranges.
    assign sh6 = mprod6_reg >>> 16;
    always_comb
    begin
        if (big_reg[5])
        begin
            mu6 = 67'($signed({1'b0, carry_reg[5].mu_d}));
        end
        else if (mid_reg[5])
        begin
            mu6 = 67'($signed({1'b0, carry_reg[5].mu_s})) - 67'(sh6);
        end
        else
        begin
            mu6 = 67'(sh6);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    // Side values shift along with each request.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_reg[0] <= carry_in;
            speed_reg[0] <= speed;
            nz_reg[0]    <= nz;
            for (int i = 1; i < N; i++)
            begin
                carry_reg[i] <= carry_reg[i-1];
                speed_reg[i] <= speed_reg[i-1];
                nz_reg[i]    <= nz_reg[i-1];
            end
        end
    end

    // Arithmetic stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp1_reg <= speed * inv_tol;

            mid_reg[1] <= (s1 >= 47'd65536);
            big_reg[1] <= (s1 >= 47'd196608);
            u2_reg     <= (s1 >= 47'd65536) ? sm1[16:1] : s1[15:0];
            for (int i = 2; i <= 5; i++)
            begin
                mid_reg[i] <= mid_reg[i-1];
                big_reg[i] <= big_reg[i-1];
            end

            uu3_reg <= u2_reg * u2_reg;
            pl3_reg <= $signed({1'b0, u2_reg}) * lin2;
            u3_reg  <= u2_reg;

            u3p4_reg  <= uu3_reg[31:16] * u3_reg;
            poly4_reg <= polyw3[19:0];

            stp5_reg <= u3p4_reg[31:16] * poly4_reg;

            mprod6_reg <= mult5 * $signed({1'b0, step5});

            mu7_reg <= pcfs_pkg::sat32(mu6);

            ftp8_reg <= mu7_reg * $signed(carry_reg[6].fn);

            ft9_reg <= pcfs_pkg::sat32(67'(ftp8_reg >>> 16));

            for (int i = 0; i < 3; i++)
            begin
                np10_reg[i] <= ft9_reg * $signed(carry_reg[8].vt[i]);
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign np        = np10_reg;
    assign speed_out = speed_reg[N-1];
    assign nz_out    = nz_reg[N-1];
    assign carry_out = carry_reg[N-1];

endmodule

`default_nettype wire

### sv/pcfs_div.sv
`default_nettype none

// Three-lane restoring divider for ft*vt_i / speed, then the final force sum.
module pcfs_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [2:0][63:0]       np,
    input  wire logic [31:0]            speed,
    input  wire logic                   nz,
    input  wire pcfs_pkg::pcfs_carry_t  carry_in,
    output logic                        out_valid,
    output pcfs_pkg::pcfs_out_t         out_data
);

    typedef struct packed {
        logic [2:0][31:0] rem;
        logic [2:0][31:0] low;
        logic [2:0][31:0] q;
        logic [2:0]       neg;
        logic [31:0]      den;
        logic             nz;
        pcfs_pkg::pcfs_carry_t carry;
    } div_st_t;

    localparam int N = pcfs_pkg::DIV_STEPS;

    logic [N+1:0]        vld_reg;
    div_st_t             st_reg [0:N];
    pcfs_pkg::pcfs_out_t out_reg;

    logic [2:0][63:0]    mag;
    logic signed [31:0]  fsum [3];

    // Magnitudes of the dividends.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = np[i][63] ? 64'(-np[i]) : np[i];
        end
    end

    // Signed quotient added to the normal force component.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [32:0] qs;
            qs = st_reg[N].neg[i] ? -$signed({1'b0, st_reg[N].q[i]})
                                  : $signed({1'b0, st_reg[N].q[i]});
            if (st_reg[N].nz)
            begin
                fsum[i] = pcfs_pkg::sat32(67'($signed(st_reg[N].carry.fnv[i])) + 67'(qs));
            end
            else
            begin
                fsum[i] = st_reg[N].carry.fnv[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N:0], in_valid};
        end
    end

    // Setup stage: split each magnitude into the starting remainder and low bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                st_reg[0].rem[i] <= mag[i][63:32];
                st_reg[0].low[i] <= mag[i][31:0];
                st_reg[0].q[i]   <= '0;
                st_reg[0].neg[i] <= np[i][63];
            end
            st_reg[0].den   <= speed;
            st_reg[0].nz    <= nz;
            st_reg[0].carry <= carry_in;
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_step
        logic [2:0][32:0] r;
        logic [2:0]       ge;

        // One quotient bit per lane.
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                r[i]  = {st_reg[g].rem[i], st_reg[g].low[i][31]};
                ge[i] = (r[i] >= {1'b0, st_reg[g].den});
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    st_reg[g+1].rem[i] <= ge[i] ? 32'(r[i] - {1'b0, st_reg[g].den}) : r[i][31:0];
                    st_reg[g+1].low[i] <= {st_reg[g].low[i][30:0], 1'b0};
                    st_reg[g+1].q[i]   <= {st_reg[g].q[i][30:0], ge[i]};
                end
                st_reg[g+1].neg   <= st_reg[g].neg;
                st_reg[g+1].den   <= st_reg[g].den;
                st_reg[g+1].nz    <= st_reg[g].nz;
                st_reg[g+1].carry <= st_reg[g].carry;
            end
        end
    end

    // Output register: zero force when there is no contact.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (st_reg[N].carry.contact)
            begin
                out_reg.force_x <= fsum[0];
                out_reg.force_y <= fsum[1];
                out_reg.force_z <= fsum[2];
            end
            else
            begin
                out_reg.force_x <= '0;
                out_reg.force_y <= '0;
                out_reg.force_z <= '0;
            end
            out_reg.in_contact <= st_reg[N].carry.contact;
        end
    end

    assign out_valid = vld_reg[N+1];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### sv/penalty_contact_force_stribeck.sv
`default_nettype none

// Penalty contact force with Stribeck friction. Each request carries one contact
// pair and yields one result, in order; a new request can be accepted in every
// cycle while in_stall is low. Most of the pipeline depth lies in the two
// bit-per-stage units: a 32-stage square root for the tangential speed and a
// 32-stage three-lane divider for the friction direction, with ten multiply
// stages before each of them. The whole pipeline advances together and holds
// when a finished result is stalled at the output, so in_stall follows
// out_stall while out_valid is high. Configuration registers are written
// through cfg_wr_en, cfg_index and cfg_data; writes to index 3 are ignored.
module penalty_contact_force_stribeck (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [30:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire pcfs_pkg::pcfs_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output pcfs_pkg::pcfs_out_t      out_data
);

    logic [30:0] stiffness_reg;
    logic [30:0] damping_reg;
    logic [30:0] inv_tol_reg;

    logic en;

    logic                  f_valid;
    logic [63:0]           f_sq;
    pcfs_pkg::pcfs_carry_t f_carry;

    logic                  s_valid;
    logic [31:0]           s_root;
    logic                  s_nz;
    pcfs_pkg::pcfs_carry_t s_carry;

    logic                  m_valid;
    logic [2:0][63:0]      m_np;
    logic [31:0]           m_speed;
    logic                  m_nz;
    pcfs_pkg::pcfs_carry_t m_carry;

    // The pipeline moves unless a finished result is held at the output.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= '0;
            damping_reg   <= '0;
            inv_tol_reg   <= pcfs_pkg::INV_TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pcfs_pkg::REG_STIFFNESS: stiffness_reg <= cfg_data;
                pcfs_pkg::REG_DAMPING:   damping_reg   <= cfg_data;
                pcfs_pkg::REG_INV_TOL:   inv_tol_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    pcfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .k         (stiffness_reg),
        .d         (damping_reg),
        .out_valid (f_valid),
        .sq        (f_sq),
        .carry     (f_carry)
    );

    pcfs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .sq        (f_sq),
        .carry_in  (f_carry),
        .out_valid (s_valid),
        .root      (s_root),
        .nz        (s_nz),
        .carry_out (s_carry)
    );

    pcfs_fric u_fric (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .speed     (s_root),
        .nz        (s_nz),
        .carry_in  (s_carry),
        .inv_tol   (inv_tol_reg),
        .out_valid (m_valid),
        .np        (m_np),
        .speed_out (m_speed),
        .nz_out    (m_nz),
        .carry_out (m_carry)
    );

    pcfs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .np        (m_np),
        .speed     (m_speed),
        .nz        (m_nz),
        .carry_in  (m_carry),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### sv/pcfs_checker.sv
`default_nettype none

`include "penalty_contact_force_stribeck_macros.svh"

// Port-level checks of the contact force block.
module pcfs_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire pcfs_pkg::pcfs_out_t out_data
);

    // No result is shown while reset is applied.
    `PCFS_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "result valid during reset")

    // A result without contact carries zero force.
    `PCFS_ASSERT(a_no_contact_zero, out_valid && !out_data.in_contact |-> out_data.force_x == 32'sd0 && out_data.force_y == 32'sd0 && out_data.force_z == 32'sd0, "force without contact")

    // The intake only stalls behind a blocked result.
    `PCFS_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "intake stalled without cause")

    // A stalled result stays put.
    `PCFS_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

endmodule

bind penalty_contact_force_stribeck pcfs_checker u_pcfs_checker (.*);

`default_nettype wire
